// ===== src/dnsar_pkg.sv =====
`default_nettype none
package dnsar_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned HDR_POS_W = 4;
    localparam int unsigned LABEL_W = 7;
    localparam int unsigned TAIL_W = 2;
    localparam int unsigned ANS_IDX_W = 4;

    // header layout
    localparam logic [HDR_POS_W-1:0] HDR_FIX_FIRST = 4'd2;
    localparam logic [HDR_POS_W-1:0] HDR_FIX_LAST = 4'd7;
    localparam logic [HDR_POS_W-1:0] HDR_LAST_POS = 4'd11;
    localparam logic [TAIL_W-1:0] TAIL_END = 2'd3;
    localparam logic [ANS_IDX_W-1:0] ANS_LAST_IDX = 4'd15;

    // fixed byte values
    localparam logic [BYTE_W-1:0] FLAGS_HI = 8'h81;
    localparam logic [BYTE_W-1:0] FLAGS_LO = 8'h80;
    localparam logic [BYTE_W-1:0] PTR_HI = 8'hc0;
    localparam logic [BYTE_W-1:0] PTR_LO = 8'h0c;
    localparam logic [BYTE_W-1:0] RDLEN_LO = 8'h04;
    localparam logic [WORD_W-1:0] TTL_RESET = 32'h0000_005f;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_LENGTH = 3'd1,
        PH_LABEL  = 3'd2,
        PH_TAIL   = 3'd3,
        PH_DROP   = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        K_NONE   = 2'd0,
        K_ONE    = 2'd1,
        K_ANSWER = 2'd2
    } t_kind;

    // parser result for one accepted word
    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              bad;
    } t_parse_res;

    // header bytes 2 to 7 of the response
    function automatic logic [BYTE_W-1:0] f_hdr_fixed(input logic [HDR_POS_W-1:0] pos);
        logic [BYTE_W-1:0] v;
        case (pos)
            4'd2:    v = FLAGS_HI;
            4'd3:    v = FLAGS_LO;
            4'd5:    v = 8'h01;
            4'd7:    v = 8'h01;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // answer record byte at a given offset
    function automatic logic [BYTE_W-1:0] f_answer_byte(
        input logic [ANS_IDX_W-1:0] idx,
        input logic [WORD_W-1:0]    ttl,
        input logic [WORD_W-1:0]    ip
    );
        logic [BYTE_W-1:0] v;
        case (idx)
            4'd0:    v = PTR_HI;
            4'd1:    v = PTR_LO;
            4'd3:    v = 8'h01;
            4'd5:    v = 8'h01;
            4'd6:    v = ttl[31:24];
            4'd7:    v = ttl[23:16];
            4'd8:    v = ttl[15:8];
            4'd9:    v = ttl[7:0];
            4'd11:   v = RDLEN_LO;
            4'd12:   v = ip[31:24];
            4'd13:   v = ip[23:16];
            4'd14:   v = ip[15:8];
            4'd15:   v = ip[7:0];
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== src/dnsar_parser.sv =====
`default_nettype none
module dnsar_parser (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_accept,
    input  wire logic [dnsar_pkg::BYTE_W-1:0] i_byte,
    input  wire logic                       i_last,
    output dnsar_pkg::t_parse_res           o_res
);

    dnsar_pkg::t_phase                    r_phase, n_phase;
    logic [dnsar_pkg::HDR_POS_W-1:0]      r_hdr_pos, n_hdr_pos;
    logic [dnsar_pkg::LABEL_W-1:0]        r_label_rem, n_label_rem;
    logic [dnsar_pkg::TAIL_W-1:0]         r_tail_cnt, n_tail_cnt;
    logic [dnsar_pkg::LABEL_W-1:0]        label_dec;
    logic                                 restart;

    assign label_dec = r_label_rem - 7'd1;

    // next state
    always_comb begin
        n_phase = r_phase;
        n_hdr_pos = r_hdr_pos;
        n_label_rem = r_label_rem;
        n_tail_cnt = r_tail_cnt;
        restart = 1'b0;
        unique case (r_phase)
            dnsar_pkg::PH_HEADER: begin
                if (r_hdr_pos == dnsar_pkg::HDR_LAST_POS) begin
                    n_hdr_pos = '0;
                    n_phase = dnsar_pkg::PH_LENGTH;
                end else begin
                    n_hdr_pos = r_hdr_pos + 4'd1;
                end
                restart = i_last;
            end
            dnsar_pkg::PH_LENGTH: begin
                if (i_byte == 8'h00) begin
                    n_tail_cnt = '0;
                    n_phase = dnsar_pkg::PH_TAIL;
                end else if (!i_byte[7]) begin
                    n_label_rem = i_byte[6:0];
                    n_phase = dnsar_pkg::PH_LABEL;
                end
                restart = i_last;
            end
            dnsar_pkg::PH_LABEL: begin
                n_label_rem = label_dec;
                if (label_dec == '0) begin
                    n_phase = dnsar_pkg::PH_LENGTH;
                end
                restart = i_last;
            end
            dnsar_pkg::PH_TAIL: begin
                if (r_tail_cnt == dnsar_pkg::TAIL_END) begin
                    n_tail_cnt = '0;
                    n_phase = dnsar_pkg::PH_DROP;
                end else begin
                    n_tail_cnt = r_tail_cnt + 2'd1;
                end
                restart = i_last;
            end
            dnsar_pkg::PH_DROP: begin
                restart = i_last;
            end
            default: begin
                restart = 1'b1;
            end
        endcase
        if (restart) begin
            n_phase = dnsar_pkg::PH_HEADER;
            n_hdr_pos = '0;
            n_label_rem = '0;
            n_tail_cnt = '0;
        end
    end

    // result for the current word
    always_comb begin
        o_res.kind = dnsar_pkg::K_ONE;
        o_res.data = i_byte;
        o_res.last = i_last;
        o_res.bad = i_last;
        unique case (r_phase)
            dnsar_pkg::PH_HEADER: begin
                if (r_hdr_pos >= dnsar_pkg::HDR_FIX_FIRST &&
                    r_hdr_pos <= dnsar_pkg::HDR_FIX_LAST) begin
                    o_res.data = dnsar_pkg::f_hdr_fixed(r_hdr_pos);
                end
            end
            dnsar_pkg::PH_TAIL: begin
                // class complete: byte goes out, answer follows
                if (r_tail_cnt == dnsar_pkg::TAIL_END) begin
                    o_res.kind = dnsar_pkg::K_ANSWER;
                    o_res.last = 1'b0;
                    o_res.bad = 1'b0;
                end
            end
            dnsar_pkg::PH_DROP: begin
                o_res.kind = dnsar_pkg::K_NONE;
                o_res.last = 1'b0;
                o_res.bad = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= dnsar_pkg::PH_HEADER;
            r_hdr_pos <= '0;
            r_label_rem <= '0;
            r_tail_cnt <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_hdr_pos <= n_hdr_pos;
            r_label_rem <= n_label_rem;
            r_tail_cnt <= n_tail_cnt;
        end
    end

endmodule
`default_nettype wire

// ===== src/dnsar_emitter.sv =====
`default_nettype none
module dnsar_emitter (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_accept,
    input  wire dnsar_pkg::t_parse_res        i_res,
    input  wire logic [dnsar_pkg::WORD_W-1:0] i_ip,
    input  wire logic [dnsar_pkg::WORD_W-1:0] i_ttl,
    input  wire logic                         i_m_tready,
    output logic                              o_ready,
    output logic                              o_m_tvalid,
    output logic [dnsar_pkg::BYTE_W-1:0]      o_m_tdata,
    output logic                              o_m_tlast,
    output logic                              o_m_tuser
);

    logic                             r_valid, n_valid;
    logic [dnsar_pkg::BYTE_W-1:0]     r_data, n_data;
    logic                             r_last, n_last;
    logic                             r_bad, n_bad;
    logic                             r_pend, n_pend;
    logic [dnsar_pkg::ANS_IDX_W-1:0]  r_idx, n_idx;
    logic [dnsar_pkg::WORD_W-1:0]     r_ip, n_ip;
    logic                             fire_out;

    assign fire_out = r_valid && i_m_tready;
    // a new word fits when the result register frees up and no answer is queued
    assign o_ready = (!r_valid || i_m_tready) && !r_pend;

    // result register and answer sequencer
    always_comb begin
        n_valid = r_valid;
        n_data = r_data;
        n_last = r_last;
        n_bad = r_bad;
        n_pend = r_pend;
        n_idx = r_idx;
        n_ip = r_ip;
        if (i_accept && i_res.kind != dnsar_pkg::K_NONE) begin
            n_valid = 1'b1;
            n_data = i_res.data;
            n_last = i_res.last;
            n_bad = i_res.bad;
            if (i_res.kind == dnsar_pkg::K_ANSWER) begin
                n_pend = 1'b1;
                n_idx = '0;
                n_ip = i_ip;
            end
        end else if (fire_out && r_pend) begin
            n_valid = 1'b1;
            n_data = dnsar_pkg::f_answer_byte(r_idx, i_ttl, r_ip);
            n_last = (r_idx == dnsar_pkg::ANS_LAST_IDX);
            n_bad = 1'b0;
            n_idx = r_idx + 4'd1;
            if (r_idx == dnsar_pkg::ANS_LAST_IDX) begin
                n_pend = 1'b0;
            end
        end else if (fire_out) begin
            n_valid = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend <= 1'b0;
            r_idx <= '0;
        end else begin
            r_valid <= n_valid;
            r_pend <= n_pend;
            r_idx <= n_idx;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_last <= n_last;
        r_bad <= n_bad;
        r_ip <= n_ip;
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata = r_data;
    assign o_m_tlast = r_last;
    assign o_m_tuser = r_bad;

endmodule
`default_nettype wire

// ===== src/dns_a_answer_rewriter_core.sv =====
// output: each reply word is registered and appears in the cycle after its query word is accepted
// throughput: one query word per cycle while the reply side is not stalled; the word that
//   ends the class holds the input while the 16-byte answer record is sent
// reset: synchronous active-low i_rst_n returns the parser to the header,
//   empties the result register and sets the ttl register to 95
`default_nettype none
module dns_a_answer_rewriter_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // query stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [39:0] i_s_tdata,   // request_byte [7:0], answer_ipv4 [39:8]
    input  wire logic        i_s_tlast,
    // reply stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,   // reply_byte [7:0]
    output logic             o_m_tlast,
    output logic             o_m_tuser,   // malformed [0]
    // ttl register write
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data
);

    logic [dnsar_pkg::WORD_W-1:0] r_answer_ttl;
    logic                         in_ready;
    logic                         accept;
    dnsar_pkg::t_parse_res        parse_res;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready = in_ready;
    assign accept = i_s_tvalid && in_ready;

    // ttl register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_answer_ttl <= dnsar_pkg::TTL_RESET;
        end else if (i_cfg_valid) begin
            r_answer_ttl <= i_cfg_data;
        end
    end

    dnsar_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_tdata[7:0]),
        .i_last   (i_s_tlast),
        .o_res    (parse_res)
    );

    dnsar_emitter u_emitter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_res      (parse_res),
        .i_ip       (i_s_tdata[39:8]),
        .i_ttl      (r_answer_ttl),
        .i_m_tready (i_m_tready),
        .o_ready    (in_ready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
`default_nettype wire

// ===== src/dnsar_checker.sv =====
`default_nettype none
module dnsar_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_s_tready,
    input wire logic       o_m_tvalid,
    input wire logic       i_m_tready,
    input wire logic [7:0] o_m_tdata,
    input wire logic       o_m_tlast,
    input wire logic       o_m_tuser
);

    // a malformed flag only rides on the closing word of a reply
    a_bad_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tlast)
        else $error("malformed word without tlast");

    // a stalled result register blocks the query side
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("query accepted while reply stalled");

    // no reply word straight out of reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("reply valid right after reset");

    // a stalled reply word holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) &&
            $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("reply word changed under stall");

endmodule

bind dns_a_answer_rewriter_core dnsar_checker u_dnsar_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);
`default_nettype wire
